// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the parser RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ifp_pkg.sv =====
`default_nettype none

package ifp_pkg;

  // One input word: a character and the start-of-field flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic [2:0]         status;
    logic [7:0]         stop_char;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_FIRST      = 3'd1,
    ST_TOO_MANY       = 3'd2,
    ST_OUT_OF_RANGE   = 3'd3,
    ST_EMPTY_SYMBOL   = 3'd4,
    ST_UNKNOWN_SYMBOL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    MODE_BLANK,
    MODE_SIGNED,
    MODE_FIRST,
    MODE_DIGITS,
    MODE_SYMBOL
  } mode_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_BIN,
    RADIX_HEX
  } radix_t;

  // Configuration register indexes.
  localparam logic REG_MIN_VALUE = 1'b0;
  localparam logic REG_MAX_VALUE = 1'b1;

  localparam logic signed [31:0] MIN_VALUE_RESET = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VALUE_RESET = 32'sh7FFF_FFFF;

  localparam int ACC_W = 35;
  localparam int VAL_W = ACC_W + 1;
  localparam int COUNT_W = 6;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_B_LOW  = "b";
  localparam logic [7:0] CH_B_UP   = "B";

  // Symbol table. Names are right aligned so the newest character is the low byte.
  localparam int NUM_SYMBOLS = 29;
  localparam int SYM_CHARS = 9;
  localparam int SYM_W = SYM_CHARS * 8;
  localparam int SYM_LEN_W = 4;

  localparam logic [SYM_W-1:0] SYM_TEXT [NUM_SYMBOLS] = '{
    72'("vdig"), 72'("vana"), 72'("vsh"), 72'("vcomp"), 72'("leak"), 72'("rgpr"),
    72'("wllpr"), 72'("rgsh"), 72'("wllsh"), 72'("hlddel"), 72'("trim"), 72'("thr"),
    72'({"bias_", "bus"}), 72'("bias_sf"), 72'({"offset_", "op"}), 72'("bias_op"),
    72'({"offset_", "ro"}), 72'("ion"), 72'("bias_ph"), 72'({"bias_", "dac"}),
    72'({"bias_", "roc"}),
    72'("color"), 72'("npix"), 72'("sumcol"), 72'("cal"), 72'("caldel"),
    72'("rangetemp"), 72'("wbc"), 72'("ctrl")
  };

  localparam logic [SYM_LEN_W-1:0] SYM_LEN [NUM_SYMBOLS] = '{
    4'd4, 4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd3,
    4'd8, 4'd7, 4'd9, 4'd7, 4'd9, 4'd3, 4'd7, 4'd8, 4'd8, 4'd5, 4'd4, 4'd6,
    4'd3, 4'd6, 4'd9, 4'd3, 4'd4
  };

  localparam logic [7:0] SYM_VAL [NUM_SYMBOLS] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
    8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'hFE, 8'hFD
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  typedef struct packed {
    logic       found;
    logic [7:0] value;
  } sym_hit_t;

  // Result of one parse step, passed from the core to the top level.
  typedef struct packed {
    logic      hit;
    out_word_t word;
  } step_res_t;

  // Digit value of a character in the given radix.
  function automatic digit_t digit_of(input logic [7:0] c, input radix_t r);
    digit_t     res;
    logic       ok;
    logic [3:0] d;
    ok = 1'b1;
    d = 4'd0;
    if (c >= "0" && c <= "9") begin
      d = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      d = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      d = 4'(c - "a" + 8'd10);
    end else begin
      ok = 1'b0;
    end
    unique case (r)
      RADIX_BIN: res.ok = ok && (d < 4'd2);
      RADIX_HEX: res.ok = ok;
      default:   res.ok = ok && (d < 4'd10);
    endcase
    res.value = d;
    return res;
  endfunction

  function automatic logic [COUNT_W-1:0] max_digits(input radix_t r);
    logic [COUNT_W-1:0] n;
    unique case (r)
      RADIX_BIN: n = COUNT_W'(32);
      RADIX_HEX: n = COUNT_W'(8);
      default:   n = COUNT_W'(10);
    endcase
    return n;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  // Table search; only the low len bytes of text are meaningful.
  function automatic sym_hit_t sym_lookup(input logic [SYM_W-1:0] text,
                                          input logic [SYM_LEN_W-1:0] len);
    sym_hit_t res;
    logic     match;
    res.found = 1'b0;
    res.value = 8'h00;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      match = (len == SYM_LEN[i]);
      for (int k = 0; k < SYM_CHARS; k++) begin
        if (k < int'(len) && text[k*8 +: 8] != SYM_TEXT[i][k*8 +: 8]) begin
          match = 1'b0;
        end
      end
      if (match && !res.found) begin
        res.found = 1'b1;
        res.value = SYM_VAL[i];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ifp_core.sv =====
`default_nettype none

module ifp_core
  import ifp_pkg::*;
#(
  parameter int MAX_SYMBOL_LENGTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  in_word_t           item,
  input  logic signed [31:0] min_value,
  input  logic signed [31:0] max_value,
  output step_res_t          res
);

  localparam int LEN_W = $clog2(MAX_SYMBOL_LENGTH + 1);

  // Parse state.
  mode_t              mode, mode_next;
  logic               negative, negative_next;
  radix_t             radix_sel, radix_next;
  logic [COUNT_W-1:0] digit_count, digit_count_next;
  logic [ACC_W-1:0]   accumulator, accumulator_next;
  logic [LEN_W-1:0]   symbol_length, symbol_length_next;
  logic               field_done, field_done_next;
  logic [SYM_W-1:0]   symbol_chars, symbol_chars_next;

  // Working values for the current word.
  mode_t                   mode_cur;
  logic                    negative_cur;
  radix_t                  radix_cur;
  logic [COUNT_W-1:0]      count_cur;
  logic [ACC_W-1:0]        acc_cur;
  logic [LEN_W-1:0]        len_cur;
  logic                    done_cur;
  logic                    to_signed, to_first;
  logic [7:0]              c;
  digit_t                  dig;
  sym_hit_t                sym;
  logic                    check_range;
  status_t                 status_raw;
  logic signed [VAL_W-1:0] value_raw;
  logic signed [VAL_W-1:0] min_ext, max_ext;
  logic [ACC_W-1:0]        acc_step;

  assign c = item.ch;
  assign min_ext = {{(VAL_W-32){min_value[31]}}, min_value};
  assign max_ext = {{(VAL_W-32){max_value[31]}}, max_value};

  // A new field restarts from the reset state.
  always_comb begin
    mode_cur     = item.first ? MODE_BLANK : mode;
    negative_cur = item.first ? 1'b0 : negative;
    radix_cur    = item.first ? RADIX_DEC : radix_sel;
    count_cur    = item.first ? '0 : digit_count;
    acc_cur      = item.first ? '0 : accumulator;
    len_cur      = item.first ? '0 : symbol_length;
    done_cur     = item.first ? 1'b0 : field_done;
  end

  assign dig = digit_of(c, radix_cur);
  assign sym = sym_lookup(symbol_chars, SYM_LEN_W'(len_cur));

  // Accumulator times the radix plus the new digit.
  always_comb begin
    unique case (radix_cur)
      RADIX_BIN: acc_step = (acc_cur << 1) + ACC_W'(dig.value);
      RADIX_HEX: acc_step = (acc_cur << 4) + ACC_W'(dig.value);
      default:   acc_step = (acc_cur << 3) + (acc_cur << 1) + ACC_W'(dig.value);
    endcase
  end

  // One parse step: next state and an optional result.
  always_comb begin
    mode_next          = mode_cur;
    negative_next      = negative_cur;
    radix_next         = radix_cur;
    digit_count_next   = count_cur;
    accumulator_next   = acc_cur;
    symbol_length_next = len_cur;
    symbol_chars_next  = symbol_chars;
    to_signed          = 1'b0;
    to_first           = 1'b0;
    res.hit            = 1'b0;
    status_raw         = ST_OK;
    value_raw          = '0;
    check_range        = 1'b0;

    if (!done_cur) begin
      // Leading blanks, symbol marker and sign.
      if (mode_cur == MODE_BLANK) begin
        if (c == CH_SPACE || c == CH_TAB) begin
          mode_next = MODE_BLANK;
        end else if (c == CH_HASH) begin
          mode_next = MODE_SYMBOL;
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          negative_next = (c == CH_MINUS);
          mode_next = MODE_SIGNED;
        end else begin
          to_signed = 1'b1;
        end
      end

      // Radix prefix.
      if (mode_cur == MODE_SIGNED || to_signed) begin
        if (c == CH_B_LOW || c == CH_B_UP) begin
          radix_next = RADIX_BIN;
          mode_next = MODE_FIRST;
        end else if (c == CH_DOLLAR) begin
          radix_next = RADIX_HEX;
          mode_next = MODE_FIRST;
        end else begin
          to_first = 1'b1;
        end
      end

      // First digit.
      if (mode_cur == MODE_FIRST || to_first) begin
        if (!dig.ok) begin
          res.hit = 1'b1;
          status_raw = ST_BAD_FIRST;
        end else begin
          accumulator_next = ACC_W'(dig.value);
          digit_count_next = COUNT_W'(1);
          mode_next = MODE_DIGITS;
        end
      end

      // Further digits, or the end of a number.
      if (mode_cur == MODE_DIGITS) begin
        if (dig.ok) begin
          if (count_cur >= max_digits(radix_cur)) begin
            res.hit = 1'b1;
            status_raw = ST_TOO_MANY;
          end else begin
            accumulator_next = acc_step;
            digit_count_next = count_cur + COUNT_W'(1);
          end
        end else begin
          res.hit = 1'b1;
          check_range = 1'b1;
          value_raw = negative_cur ? -$signed({1'b0, acc_cur}) : $signed({1'b0, acc_cur});
        end
      end

      // Symbol name characters, or the end of the symbol.
      if (mode_cur == MODE_SYMBOL) begin
        if (len_cur < LEN_W'(MAX_SYMBOL_LENGTH) && is_name_char(c)) begin
          symbol_chars_next = {symbol_chars[SYM_W-9:0], c};
          symbol_length_next = len_cur + LEN_W'(1);
        end else begin
          res.hit = 1'b1;
          if (len_cur == '0) begin
            status_raw = ST_EMPTY_SYMBOL;
          end else if (len_cur <= LEN_W'(SYM_CHARS) && sym.found) begin
            check_range = 1'b1;
            value_raw = $signed({{(VAL_W-8){1'b0}}, sym.value});
          end else begin
            status_raw = ST_UNKNOWN_SYMBOL;
          end
        end
      end
    end

    if (check_range && (value_raw < min_ext || value_raw > max_ext)) begin
      status_raw = ST_OUT_OF_RANGE;
    end
    field_done_next = done_cur || res.hit;

    res.word.parsed_value = (status_raw == ST_OK) ? value_raw[31:0] : 32'sd0;
    res.word.status       = status_raw;
    res.word.stop_char    = c;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_BLANK;
      negative      <= 1'b0;
      radix_sel     <= RADIX_DEC;
      digit_count   <= '0;
      accumulator   <= '0;
      symbol_length <= '0;
      field_done    <= 1'b0;
    end else if (fire) begin
      mode          <= mode_next;
      negative      <= negative_next;
      radix_sel     <= radix_next;
      digit_count   <= digit_count_next;
      accumulator   <= accumulator_next;
      symbol_length <= symbol_length_next;
      field_done    <= field_done_next;
    end
  end

  // Symbol name shift line; only the bytes below the length are read.
  always_ff @(posedge clk) begin
    if (fire) begin
      symbol_chars <= symbol_chars_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_field_parser.sv =====
`default_nettype none
`include "assert_macros.svh"

// Channel  | Handshake                 | Word
// ---------+---------------------------+-------------------------------------
// in       | in_valid / in_ready       | in_data: ch, first
// out      | out_valid / out_ready     | out_data: parsed_value, status, stop_char
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// One character is taken every cycle as long as results are taken; it is parsed
// from the input register and its result, if any, appears in the output register.
// Throughput is one word per cycle as long as results are taken.
// A result waiting in the output register only stalls a word that has its own
// result; words that give no result keep flowing.
// Reset is synchronous; it clears the parse state and loads the range limits.

module integer_field_parser
  import ifp_pkg::*;
#(
  parameter int MAX_SYMBOL_LENGTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic               stage_valid;
  in_word_t           stage_word;
  logic               step_fire;
  logic               out_free;
  step_res_t          res;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= MIN_VALUE_RESET;
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_VALUE: min_value <= $signed(cfg_data);
        REG_MAX_VALUE: max_value <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Handshake: a word leaves the input register unless its result is blocked.
  assign out_free  = !out_valid || out_ready;
  assign step_fire = stage_valid && (!res.hit || out_free);
  assign in_ready  = !stage_valid || step_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (step_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_word <= in_data;
    end
  end

  ifp_core #(
    .MAX_SYMBOL_LENGTH(MAX_SYMBOL_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (step_fire),
    .item     (stage_word),
    .min_value(min_value),
    .max_value(max_value),
    .res      (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire && res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res.hit) begin
      out_data <= res.word;
    end
  end

  // An error result never carries a value.
  `ASSERT_SAME(a_err_zero, out_valid && out_data.status != ST_OK, out_data.parsed_value == 32'sd0, "error result with nonzero value")
  // A word that cannot move stays in the input register unchanged.
  `ASSERT_NEXT(a_stage_hold, stage_valid && !step_fire, stage_valid && $stable(stage_word), "stalled input word lost")
  // A result is only produced when the output register can take it.
  `ASSERT_SAME(a_no_overwrite, step_fire && res.hit, out_free, "result overwrote a pending word")

endmodule

`default_nettype wire
